// ===== rtl/core/prfr_pkg.sv =====
// ----------------------------------------------------------------------------
// prfr_pkg: shared definitions for the preamble frame receiver
// Holds the frame constants, the result layout and the CRC-16 table function.
// ----------------------------------------------------------------------------
`default_nettype none

package prfr_pkg;

  localparam int unsigned MAX_FRAME     = 64;
  // A frame adds eight bytes of overhead to the length field.
  localparam int unsigned FRAME_OVERHEAD = 8;
  localparam logic [16:0] OVERSIZE_LIMIT = 17'(MAX_FRAME - FRAME_OVERHEAD);

  localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  localparam int unsigned RESULT_W = 80;

  typedef struct packed {
    logic        oversize;
    logic        checksum_ok;
    logic [31:0] first_data_word;
    logic [15:0] payload_length;
    logic [15:0] status_word;
    logic [7:0]  command_id;
  } result_t;

  // MSB-first remainder of idx << 8 by the CCITT polynomial.
  function automatic logic [15:0] crc_table_entry(input logic [7:0] idx);
    logic [15:0] c;
    c = {idx, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/prfr_crc_update.sv =====
// ----------------------------------------------------------------------------
// prfr_crc_update: one-byte CRC-16 fold
// Folds one byte into the running checksum with a table lookup and a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module prfr_crc_update (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);

  logic [7:0] idx;

  assign idx     = crc_in[7:0] ^ data;
  assign crc_out = prfr_pkg::crc_table_entry(idx) ^ {8'h00, crc_in[15:8]};

endmodule

`default_nettype wire

// ===== rtl/core/preamble_frame_receiver_crc16.sv =====
// ----------------------------------------------------------------------------
// preamble_frame_receiver_crc16: byte-stream deframer with CRC-16 check
// Finds the preamble, parses command, length and body, checks the CRC and
// reports one summary per frame.
// ----------------------------------------------------------------------------
// Pipeline: each accepted byte is held in the input register and parsed from
//   there; a frame's result is then loaded into the result register.
// Throughput: one byte per cycle. Only the byte that closes a frame waits for
//   the result register, and only while the previous result is still stalled.
// Reset (rst, synchronous, active high) empties both registers and returns
//   the parser to the start of the preamble hunt with the CRC at 0xFFFF.
// ----------------------------------------------------------------------------
`default_nettype none

module preamble_frame_receiver_crc16 (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream: one received byte per request.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Result stream: one request per completed frame.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] command_id, [23:8] status_word, [39:24] payload_length,
  // [71:40] first_data_word, [72] checksum_ok, [73] oversize, [79:74] zero
  output logic      [79:0] m_tdata
);

  typedef enum logic [2:0] {
    HUNT0, HUNT1, HUNT2, CMD, LENLO, LENHI, BODY, CRC
  } phase_t;

  // Input register.
  logic        in_valid;
  logic [7:0]  in_byte;

  // Result register.
  logic                 out_valid;
  prfr_pkg::result_t    out_result;

  // Parser state.
  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] frame_length, frame_length_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [15:0] frame_status, frame_status_next;
  logic [31:0] data_word, data_word_next;
  logic [7:0]  received_crc_low, received_crc_low_next;

  logic              emit;
  prfr_pkg::result_t result_next;
  logic [15:0]       crc_fold;
  logic [15:0]       count_inc;
  logic [15:0]       length_full;
  logic              out_free;
  logic              process;

  // The result register is free when empty or being drained this cycle. Only
  // the byte that closes a frame needs it free; every other byte is parsed
  // regardless, so a stalled result does not hold back the rest of a frame.
  assign out_free = !out_valid || m_tready;
  assign process  = in_valid && (out_free || !emit);
  assign s_tready = !in_valid || process;

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_result};

  prfr_crc_update u_crc (
    .crc_in  (running_crc),
    .data    (in_byte),
    .crc_out (crc_fold)
  );

  assign count_inc   = byte_count + 16'd1;
  assign length_full = {in_byte, frame_length[7:0]};

  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    running_crc_next      = running_crc;
    frame_length_next     = frame_length;
    frame_command_next    = frame_command;
    frame_status_next     = frame_status;
    data_word_next        = data_word;
    received_crc_low_next = received_crc_low;
    emit                  = 1'b0;

    result_next.command_id      = frame_command;
    result_next.status_word     = frame_status;
    result_next.payload_length  = frame_length;
    result_next.first_data_word = data_word;
    result_next.checksum_ok     = ({in_byte, received_crc_low} == running_crc);
    result_next.oversize        = ({1'b0, frame_length} > prfr_pkg::OVERSIZE_LIMIT);

    case (phase)
      HUNT0, HUNT1, HUNT2: begin
        if (in_byte == prfr_pkg::PREAMBLE_BYTE) begin
          running_crc_next = crc_fold;
          phase_next       = phase_t'(phase + 3'd1);
        end else begin
          // A stray byte is dropped and the hunt starts over.
          phase_next       = HUNT0;
          running_crc_next = prfr_pkg::CRC_INIT;
        end
      end
      CMD: begin
        running_crc_next   = crc_fold;
        frame_command_next = in_byte;
        phase_next         = LENLO;
      end
      LENLO: begin
        running_crc_next  = crc_fold;
        frame_length_next = {8'h00, in_byte};
        phase_next        = LENHI;
      end
      LENHI: begin
        running_crc_next  = crc_fold;
        frame_length_next = length_full;
        byte_count_next   = '0;
        // An empty body goes straight to the CRC bytes.
        phase_next        = (length_full == 16'd0) ? CRC : BODY;
      end
      BODY: begin
        running_crc_next = crc_fold;
        case (byte_count)
          16'd0:   frame_status_next[7:0]  = in_byte;
          16'd1:   frame_status_next[15:8] = in_byte;
          16'd2:   data_word_next[7:0]     = in_byte;
          16'd3:   data_word_next[15:8]    = in_byte;
          16'd4:   data_word_next[23:16]   = in_byte;
          16'd5:   data_word_next[31:24]   = in_byte;
          default: ;
        endcase
        if (count_inc >= frame_length) begin
          byte_count_next = '0;
          phase_next      = CRC;
        end else begin
          byte_count_next = count_inc;
        end
      end
      default: begin
        // CRC phase: low byte first, then the high byte closes the frame.
        if (byte_count == 16'd0) begin
          received_crc_low_next = in_byte;
          byte_count_next       = 16'd1;
        end else begin
          emit                  = 1'b1;
          phase_next            = HUNT0;
          running_crc_next      = prfr_pkg::CRC_INIT;
        end
      end
    endcase

    // Any return to the hunt clears every frame field.
    if (phase_next == HUNT0) begin
      byte_count_next       = '0;
      frame_length_next     = '0;
      frame_command_next    = '0;
      frame_status_next     = '0;
      data_word_next        = '0;
      received_crc_low_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      phase            <= HUNT0;
      byte_count       <= '0;
      running_crc      <= prfr_pkg::CRC_INIT;
      frame_length     <= '0;
      frame_command    <= '0;
      frame_status     <= '0;
      data_word        <= '0;
      received_crc_low <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_byte  <= s_tdata;
      end else if (process) begin
        in_valid <= 1'b0;
      end

      if (process) begin
        phase            <= phase_next;
        byte_count       <= byte_count_next;
        running_crc      <= running_crc_next;
        frame_length     <= frame_length_next;
        frame_command    <= frame_command_next;
        frame_status     <= frame_status_next;
        data_word        <= data_word_next;
        received_crc_low <= received_crc_low_next;
      end

      if (process && emit) begin
        out_valid  <= 1'b1;
        out_result <= result_next;
      end else if (m_tready) begin
        out_valid  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/prfr_checker.sv =====
// ----------------------------------------------------------------------------
// prfr_checker: port-level checks for the preamble frame receiver
// Watches the result stream and the input ready for consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module prfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata
);

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // The input register is empty after reset, so a byte can be taken at once.
  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The oversize flag follows the reported length, and padding is zero.
  a_oversize: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[73] == ({1'b0, m_tdata[39:24]} > prfr_pkg::OVERSIZE_LIMIT))
                 && (m_tdata[79:74] == 6'b0))
    else $error("oversize flag disagrees with length");

  // A body too short to reach the data word reports it as zero.
  a_short_body: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[39:24] < 16'd3) |-> m_tdata[71:40] == 32'd0)
    else $error("data word set beyond body length");

endmodule

bind preamble_frame_receiver_crc16 prfr_checker u_prfr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
